@@ design/nps_pkg.sv @@
// Package for the priority scheduler: sizes, item structs, job word, state codes.
package nps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LEVELS  = 4;
  localparam int MEM_DEPTH   = NUM_LEVELS * QUEUE_DEPTH;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam int TIME_W  = 16;
  localparam int ID_W    = 8;
  localparam int LEN_W   = 8;
  localparam int LEVEL_W = 3;

  localparam logic [TIME_W-1:0] TIME_MAX     = '1;
  localparam logic [TIME_W-1:0] CUTOFF_RESET = TIME_W'(100);
  localparam logic [LEN_W-1:0]  RAN_MAX      = '1;

  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [ID_W-1:0]    job_id;
    logic [LEVEL_W-1:0] job_level;
    logic [LEN_W-1:0]   job_length;
    logic [TIME_W-1:0]  job_arrival;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               busy_res;
    logic [ID_W-1:0]    running_id;
    logic               done_res;
    logic [LEVEL_W-1:0] done_level;
    logic [TIME_W-1:0]  done_arrival;
    logic [TIME_W-1:0]  done_start;
    logic [TIME_W-1:0]  done_end;
    logic               halted;
  } out_item_t;

  // One queued job, id in the low byte.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  length;
    logic [ID_W-1:0]   id;
  } job_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    job_word_t         data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

@@ design/nps_job_ram.sv @@
// Job queue storage: all level FIFOs in one RAM, one write and one registered read port.
module nps_job_ram import nps_pkg::*; (
  input  logic      clk,
  input  ram_wr_t   wr,
  input  ram_rd_t   rd,
  output job_word_t rdata_r
);

  job_word_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

endmodule

@@ design/nonpreemptive_priority_scheduler_core.sv @@
// Top level of the four-level non-preemptive priority scheduler.
//
// Usage:
//   in_valid/in_stall/in_item carry one transaction: a job arrival (mode 0) or
//   a one-quantum tick (mode 1). Every accepted transaction yields exactly one
//   result on out_valid/out_stall/out_item.
//   cfg_we/cfg_wdata write start_cutoff; write it only while the block is idle.
// Sequence:
//   The accept cycle issues, for a tick, the job RAM read of the head of the
//   lowest-numbered non-empty level; the update is applied in ST_EXEC once the
//   output register is free and loads it, raising out_valid. A new transaction
//   is accepted only in ST_IDLE, after the update of the one before.
// Stall:
//   A new transaction is taken while a result waits in the output register;
//   its own update is held until that result has been taken.
// Reset:
//   Queues empty, time zero, no active job, start_cutoff = 100. The job RAM is
//   not cleared; entries are used only after being written.
module nonpreemptive_priority_scheduler_core import nps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  in_item_t item_r;
  logic [TIME_W-1:0] cutoff_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [PTR_W-1:0]  head_r [NUM_LEVELS];
  logic [CNT_W-1:0]  cnt_r  [NUM_LEVELS];

  logic               act_valid_r, act_valid_nxt;
  logic [ID_W-1:0]    act_id_r, act_id_nxt;
  logic [LEN_W-1:0]   act_len_r, act_len_nxt;
  logic [LEVEL_W-1:0] act_level_r, act_level_nxt;
  logic [TIME_W-1:0]  act_arr_r, act_arr_nxt;
  logic [TIME_W-1:0]  act_start_r, act_start_nxt;
  logic [LEN_W-1:0]   act_ran_r, act_ran_nxt;

  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic in_fire, exec_fire;
  logic pick_found;
  logic [LVL_W-1:0] pick_q, lvl_q, sel_q;
  logic lvl_ok, sel_mode;
  logic [LEVEL_W-1:0] sel_level;
  logic [PTR_W-1:0] head_sel, slot, head_inc;
  logic [CNT_W-1:0] cnt_sel;
  logic [PTR_W:0]   slot_sum, head_sum;

  logic do_push, do_tick, do_pop;
  logic [LEN_W-1:0] run_len, run_need, run_ran, ran_inc;
  logic run_done;

  ram_wr_t   ram_wr;
  ram_rd_t   ram_rd;
  job_word_t ram_rdata;

  nps_job_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rdata_r (ram_rdata)
  );

  assign in_fire   = in_valid && !in_stall;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // Lowest-numbered non-empty level wins; counts are stable from accept to update.
  always_comb begin
    pick_found = 1'b0;
    pick_q     = '0;
    for (int q = NUM_LEVELS - 1; q >= 0; q--) begin
      if (cnt_r[q] != '0) begin
        pick_found = 1'b1;
        pick_q     = LVL_W'(q);
      end
    end
  end

  // One selected read of the head/count tables per cycle.
  assign sel_mode  = (state_r == ST_IDLE) ? in_item.mode : item_r.mode;
  assign sel_level = (state_r == ST_IDLE) ? in_item.job_level : item_r.job_level;
  assign lvl_ok    = (sel_level != '0) && (32'(sel_level) <= NUM_LEVELS);
  assign lvl_q     = LVL_W'(sel_level - LEVEL_W'(1));
  assign sel_q     = (sel_mode == MODE_TICK) ? pick_q : lvl_q;
  assign head_sel  = head_r[sel_q];
  assign cnt_sel   = cnt_r[sel_q];

  always_comb begin
    slot_sum = (PTR_W+1)'(head_sel) + (PTR_W+1)'(cnt_sel);
    if (slot_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      slot = PTR_W'(slot_sum - (PTR_W+1)'(QUEUE_DEPTH));
    end else begin
      slot = PTR_W'(slot_sum);
    end
    head_sum = (PTR_W+1)'(head_sel) + (PTR_W+1)'(1);
    if (head_sum == (PTR_W+1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end else begin
      head_inc = PTR_W'(head_sum);
    end
  end

  // RAM read of the head job at accept; the write waits for the update cycle,
  // so a read and a write never meet in one cycle.
  always_comb begin
    ram_rd.en   = in_fire && (in_item.mode == MODE_TICK);
    ram_rd.addr = ADDR_W'(pick_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_sel);
  end

  always_comb begin
    do_push = exec_fire && (item_r.mode == MODE_ARRIVAL) && lvl_ok
              && (cnt_sel < CNT_W'(QUEUE_DEPTH));
    do_tick = exec_fire && (item_r.mode == MODE_TICK)
              && (act_valid_r || (time_r < cutoff_r));
    do_pop  = do_tick && !act_valid_r && pick_found;

    ram_wr.en        = do_push;
    ram_wr.addr      = ADDR_W'(lvl_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
    ram_wr.data.id      = item_r.job_id;
    ram_wr.data.length  = item_r.job_length;
    ram_wr.data.arrival = item_r.job_arrival;
  end

  // Active job for this tick: a fresh pop or the running one.
  always_comb begin
    act_valid_nxt = act_valid_r;
    act_id_nxt    = act_id_r;
    act_len_nxt   = act_len_r;
    act_level_nxt = act_level_r;
    act_arr_nxt   = act_arr_r;
    act_start_nxt = act_start_r;
    act_ran_nxt   = act_ran_r;
    time_nxt      = time_r;
    out_nxt       = '0;

    if (do_pop) begin
      act_valid_nxt = 1'b1;
      act_id_nxt    = ram_rdata.id;
      act_len_nxt   = ram_rdata.length;
      act_level_nxt = LEVEL_W'(32'(pick_q) + 1);
      act_arr_nxt   = ram_rdata.arrival;
      act_start_nxt = time_r;
    end

    run_len  = do_pop ? ram_rdata.length : act_len_r;
    run_need = (run_len == '0) ? LEN_W'(1) : run_len;
    run_ran  = do_pop ? '0 : act_ran_r;
    ran_inc  = (run_ran != RAN_MAX) ? run_ran + LEN_W'(1) : run_ran;
    run_done = ran_inc >= run_need;

    if (item_r.mode == MODE_ARRIVAL) begin
      out_nxt.accepted = do_push;
    end

    if (do_tick) begin
      if (act_valid_nxt) begin
        out_nxt.busy_res   = 1'b1;
        out_nxt.running_id = act_id_nxt;
        act_ran_nxt        = ran_inc;
        if (run_done) begin
          out_nxt.done_res     = 1'b1;
          out_nxt.done_level   = act_level_nxt;
          out_nxt.done_arrival = act_arr_nxt;
          out_nxt.done_start   = act_start_nxt;
          out_nxt.done_end     = time_r;
          act_valid_nxt        = 1'b0;
          act_ran_nxt          = '0;
        end
      end
      if (time_r != TIME_MAX) begin
        time_nxt = time_r + TIME_W'(1);
      end
    end

    out_nxt.halted = !act_valid_nxt && (time_nxt >= cutoff_r);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cutoff_r    <= CUTOFF_RESET;
      time_r      <= '0;
      act_valid_r <= 1'b0;
      act_ran_r   <= '0;
      act_id_r    <= '0;
      act_len_r   <= '0;
      act_level_r <= '0;
      act_arr_r   <= '0;
      act_start_r <= '0;
      for (int q = 0; q < NUM_LEVELS; q++) begin
        head_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
      time_r      <= time_nxt;
      act_valid_r <= act_valid_nxt;
      act_ran_r   <= act_ran_nxt;
      act_id_r    <= act_id_nxt;
      act_len_r   <= act_len_nxt;
      act_level_r <= act_level_nxt;
      act_arr_r   <= act_arr_nxt;
      act_start_r <= act_start_nxt;
      if (do_push) begin
        cnt_r[sel_q] <= cnt_sel + CNT_W'(1);
      end
      if (do_pop) begin
        cnt_r[sel_q]  <= cnt_sel - CNT_W'(1);
        head_r[sel_q] <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
    if (exec_fire) begin
      out_r <= out_nxt;
    end
  end

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not enter update cycle");

  a_idle_job_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    !act_valid_r |-> (act_ran_r == '0))
    else $error("quantum count left over without an active job");

  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (time_r >= $past(time_r)))
    else $error("time counter went backward");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r && (state_r == ST_IDLE))
    else $error("update cycle did not produce a result");

endmodule
